>>> sv/plig_pkg.sv
package plig_pkg;

   localparam int COUNT_BITS_DEF = 16;
   localparam int MAX_DIMS_DEF   = 3;
   localparam int NDIM           = 3;

   localparam int DATA_W    = 32;
   localparam int CNT_REG_W = 17;
   localparam int PI_W      = 8;
   localparam int PC_W      = 9;
   localparam int DIR_W     = 2;
   localparam int ORG_W     = 17;
   localparam int SIG_W     = 18;
   localparam int CSR_IDX_W = 3;

   localparam logic CMD_START   = 1'b0;
   localparam logic CMD_ADVANCE = 1'b1;

   localparam logic [DIR_W-1:0] SIG_NONE = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_BASE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STRIDE_0 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STRIDE_1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_STRIDE_2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_COUNT_0  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_COUNT_1  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_COUNT_2  = 3'd6;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ADV,
      ST_TOT1,
      ST_TOT2,
      ST_NUMF,
      ST_DIVF,
      ST_WAITF,
      ST_NUML,
      ST_DIVL,
      ST_WAITL,
      ST_CHECK,
      ST_DIV2,
      ST_WAIT2,
      ST_DIV1,
      ST_WAIT1,
      ST_MAC0,
      ST_MAC1,
      ST_MAC2,
      ST_OUT
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_ADV,
      OP_TOT1,
      OP_TOT2,
      OP_NUMF,
      OP_NUML,
      OP_DIVN,
      OP_SETF,
      OP_SETL,
      OP_CHECK,
      OP_DIV2,
      OP_SET2,
      OP_DIV1,
      OP_SET1,
      OP_MAC0,
      OP_MAC1,
      OP_MAC2,
      OP_OUT
   } op_type;

   typedef struct packed {
      logic div_done;
      logic range_empty;
      logic out_free;
   } dp_stat_type;

endpackage

>>> sv/plig_if.sv
interface plig_req_if import plig_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             cmd;
   logic [PI_W-1:0]  part_index;
   logic [PC_W-1:0]  part_count;
   logic [DIR_W-1:0] sigma_dir_1;
   logic [DIR_W-1:0] sigma_dir_2;
   logic [ORG_W-1:0] sigma_origin_1;
   logic [ORG_W-1:0] sigma_origin_2;

   modport source (
      output valid, cmd, part_index, part_count, sigma_dir_1, sigma_dir_2,
             sigma_origin_1, sigma_origin_2,
      input  ready
   );
   modport sink (
      input  valid, cmd, part_index, part_count, sigma_dir_1, sigma_dir_2,
             sigma_origin_1, sigma_origin_2,
      output ready
   );
endinterface

interface plig_rsp_if import plig_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] array_index;
   logic [SIG_W-1:0]  sigma_index_1;
   logic [SIG_W-1:0]  sigma_index_2;
   logic              done_res;

   modport source (
      output valid, array_index, sigma_index_1, sigma_index_2, done_res,
      input  ready
   );
   modport sink (
      input  valid, array_index, sigma_index_1, sigma_index_2, done_res,
      output ready
   );
endinterface

interface plig_csr_if import plig_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DATA_W-1:0]    data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

>>> sv/partitioned_nested_loop_index_generator_unit.sv
// advance word: ADV steps the walk, MAC0, MAC1, MAC2 sum the address, OUT registers it
// start word: TOT1, TOT2 form the total, then four passes of the shared one-bit-per-cycle
//   divider set first, last and the start position; an empty partition skips two passes
// words are taken only in idle, even while the previous result waits in the output register
// reset: synchronous, active high; config, walk state and output valid return to defaults
module partitioned_nested_loop_index_generator_unit import plig_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEF,
   parameter int MAX_DIMS   = MAX_DIMS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   plig_req_if.sink  req_bus,
   plig_rsp_if.source rsp_bus,
   plig_csr_if.sink  csr_bus
);

   op_type      op;
   dp_stat_type stat;
   logic        req_ready;

   assign req_bus.ready = req_ready;
   assign csr_bus.ready = 1'b1;

   plig_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_cmd   (req_bus.cmd),
      .stat      (stat),
      .req_ready (req_ready),
      .op        (op)
   );

   plig_dp #(
      .COUNT_BITS (COUNT_BITS),
      .MAX_DIMS   (MAX_DIMS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .op                 (op),
      .req_cmd            (req_bus.cmd),
      .req_part_index     (req_bus.part_index),
      .req_part_count     (req_bus.part_count),
      .req_sigma_dir_1    (req_bus.sigma_dir_1),
      .req_sigma_dir_2    (req_bus.sigma_dir_2),
      .req_sigma_origin_1 (req_bus.sigma_origin_1),
      .req_sigma_origin_2 (req_bus.sigma_origin_2),
      .csr_write          (csr_bus.valid),
      .csr_index          (csr_bus.index),
      .csr_data           (csr_bus.data),
      .rsp_ready          (rsp_bus.ready),
      .stat               (stat),
      .rsp_valid          (rsp_bus.valid),
      .rsp_array_index    (rsp_bus.array_index),
      .rsp_sigma_index_1  (rsp_bus.sigma_index_1),
      .rsp_sigma_index_2  (rsp_bus.sigma_index_2),
      .rsp_done_res       (rsp_bus.done_res)
   );

endmodule

>>> sv/plig_div.sv
module plig_div import plig_pkg::*; #(
   parameter int NW = 58,
   parameter int DW = 17
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [NW-1:0] quotient,
   output logic [DW-1:0] remainder
);

   localparam int CNT_W = (NW > 1) ? $clog2(NW) : 1;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NW-1:0]    quo_ff, quo_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [DW-1:0]    dvs_ff, dvs_in;

   logic [DW:0] shifted;
   logic [DW:0] diff;
   logic        ge;

   assign shifted = {rem_ff, quo_ff[NW-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign ge      = shifted >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // one quotient bit per cycle, restoring form
         rem_in = ge ? diff[DW-1:0] : shifted[DW-1:0];
         quo_in = {quo_ff[NW-2:0], ge};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

>>> sv/plig_ctrl.sv
module plig_ctrl import plig_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_cmd,
   input  dp_stat_type stat,
   output logic        req_ready,
   output op_type      op
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      op        = OP_NONE;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op       = OP_LOAD;
               state_in = (req_cmd == CMD_ADVANCE) ? ST_ADV : ST_TOT1;
            end
         end
         ST_ADV: begin
            op       = OP_ADV;
            state_in = ST_MAC0;
         end
         ST_TOT1: begin
            op       = OP_TOT1;
            state_in = ST_TOT2;
         end
         ST_TOT2: begin
            op       = OP_TOT2;
            state_in = ST_NUMF;
         end
         ST_NUMF: begin
            op       = OP_NUMF;
            state_in = ST_DIVF;
         end
         ST_DIVF: begin
            op       = OP_DIVN;
            state_in = ST_WAITF;
         end
         ST_WAITF: begin
            if (stat.div_done) begin
               op       = OP_SETF;
               state_in = ST_NUML;
            end
         end
         ST_NUML: begin
            op       = OP_NUML;
            state_in = ST_DIVL;
         end
         ST_DIVL: begin
            op       = OP_DIVN;
            state_in = ST_WAITL;
         end
         ST_WAITL: begin
            if (stat.div_done) begin
               op       = OP_SETL;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            op       = OP_CHECK;
            state_in = stat.range_empty ? ST_MAC0 : ST_DIV2;
         end
         ST_DIV2: begin
            op       = OP_DIV2;
            state_in = ST_WAIT2;
         end
         ST_WAIT2: begin
            if (stat.div_done) begin
               op       = OP_SET2;
               state_in = ST_DIV1;
            end
         end
         ST_DIV1: begin
            op       = OP_DIV1;
            state_in = ST_WAIT1;
         end
         ST_WAIT1: begin
            if (stat.div_done) begin
               op       = OP_SET1;
               state_in = ST_MAC0;
            end
         end
         ST_MAC0: begin
            op       = OP_MAC0;
            state_in = ST_MAC1;
         end
         ST_MAC1: begin
            op       = OP_MAC1;
            state_in = ST_MAC2;
         end
         ST_MAC2: begin
            op       = OP_MAC2;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (stat.out_free) begin
               op       = OP_OUT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> sv/plig_dp.sv
module plig_dp import plig_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEF,
   parameter int MAX_DIMS   = MAX_DIMS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  op_type               op,
   input  logic                 req_cmd,
   input  logic [PI_W-1:0]      req_part_index,
   input  logic [PC_W-1:0]      req_part_count,
   input  logic [DIR_W-1:0]     req_sigma_dir_1,
   input  logic [DIR_W-1:0]     req_sigma_dir_2,
   input  logic [ORG_W-1:0]     req_sigma_origin_1,
   input  logic [ORG_W-1:0]     req_sigma_origin_2,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_data,
   input  logic                 rsp_ready,
   output dp_stat_type          stat,
   output logic                 rsp_valid,
   output logic [DATA_W-1:0]    rsp_array_index,
   output logic [SIG_W-1:0]     rsp_sigma_index_1,
   output logic [SIG_W-1:0]     rsp_sigma_index_2,
   output logic                 rsp_done_res
);

   localparam int CB     = COUNT_BITS;
   localparam int EC_W   = CB + 1;
   localparam int CMP_W  = (EC_W > CNT_REG_W) ? EC_W : CNT_REG_W;
   localparam int IT_W   = 3 * CB + 1;
   localparam int NUM_W  = IT_W + PC_W;
   localparam int DV_W   = (EC_W > PC_W) ? EC_W : PC_W;
   localparam int P01_W  = 2 * EC_W;
   localparam int TOTF_W = P01_W + EC_W;
   localparam int SUM_W  = (CB + 2 > SIG_W) ? CB + 2 : SIG_W;

   // configuration
   logic [DATA_W-1:0]    base_ff, base_in;
   logic [DATA_W-1:0]    stride_ff [NDIM];
   logic [DATA_W-1:0]    stride_in [NDIM];
   logic [CNT_REG_W-1:0] count_ff [NDIM];
   logic [CNT_REG_W-1:0] count_in [NDIM];

   // walk state
   logic [CB-1:0]   pos_ff [NDIM];
   logic [CB-1:0]   pos_in [NDIM];
   logic [IT_W-1:0] cur_ff, cur_in;
   logic [IT_W-1:0] end_ff, end_in;
   logic            fin_ff, fin_in;
   logic [DIR_W-1:0] sdir_ff [2];
   logic [DIR_W-1:0] sdir_in [2];
   logic [ORG_W-1:0] sorg_ff [2];
   logic [ORG_W-1:0] sorg_in [2];

   // working registers
   logic [PI_W-1:0]   pi_ff, pi_in;
   logic [PC_W-1:0]   pc_ff, pc_in;
   logic [P01_W-1:0]  prod01_ff, prod01_in;
   logic [IT_W-1:0]   total_ff, total_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [IT_W-1:0]   it_ff, it_in;
   logic [DATA_W-1:0] acc_ff, acc_in;

   // output word
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_index_ff, rsp_index_in;
   logic [SIG_W-1:0]  rsp_sig_ff [2];
   logic [SIG_W-1:0]  rsp_sig_in [2];
   logic              rsp_done_ff, rsp_done_in;

   logic [EC_W-1:0]   eff [NDIM];
   logic [CB-1:0]     pos_adv [NDIM];
   logic [NDIM:0]     carry;
   logic [SIG_W-1:0]  sig_val [2];

   logic [P01_W-1:0]  p01_full;
   logic [TOTF_W-1:0] tot_full;
   logic [PC_W-1:0]   pi_sel;
   logic [NUM_W-1:0]  num_full;
   logic [IT_W-1:0]   clamp_val;
   logic [IT_W-1:0]   cur_inc;
   logic [CB-1:0]     mul_pos;
   logic [DATA_W-1:0] mul_str;
   logic [DATA_W-1:0] mul_prod;

   logic              div_start;
   logic [NUM_W-1:0]  div_num;
   logic [DV_W-1:0]   div_den;
   logic              div_done;
   logic [NUM_W-1:0]  div_quo;
   logic [DV_W-1:0]   div_rem;

   // effective counts: zero reads as one, saturate at the top
   for (genvar d = 0; d < NDIM; d++) begin : g_eff
      if (d < MAX_DIMS) begin : g_act
         always_comb begin
            if (count_ff[d] == '0) begin
               eff[d] = EC_W'(1);
            end else if (CMP_W'(count_ff[d]) > (CMP_W'(1) << CB)) begin
               eff[d] = EC_W'(1) << CB;
            end else begin
               eff[d] = EC_W'(count_ff[d]);
            end
         end
      end else begin : g_off
         assign eff[d] = EC_W'(1);
      end
   end

   // odometer step, carry runs from the innermost dimension outward
   assign carry[NDIM] = 1'b1;
   for (genvar d = 0; d < NDIM; d++) begin : g_odo
      logic [EC_W-1:0] nxt;
      logic            lt;
      assign nxt = {1'b0, pos_ff[d]} + EC_W'(1);
      assign lt  = nxt < eff[d];
      assign pos_adv[d] = carry[d+1] ? (lt ? nxt[CB-1:0] : '0) : pos_ff[d];
      assign carry[d]   = carry[d+1] & ~lt;
   end

   for (genvar k = 0; k < 2; k++) begin : g_sig
      logic [CB-1:0]    pick;
      logic [SUM_W-1:0] sum;
      assign pick = (sdir_ff[k] == SIG_NONE) ? '0 : pos_ff[sdir_ff[k]];
      assign sum  = SUM_W'(sorg_ff[k]) + SUM_W'({pick, 1'b0});
      assign sig_val[k] = (sdir_ff[k] == SIG_NONE) ? '0 : sum[SIG_W-1:0];
   end

   assign p01_full  = P01_W'(eff[0]) * P01_W'(eff[1]);
   assign tot_full  = TOTF_W'(prod01_ff) * TOTF_W'(eff[2]);
   assign pi_sel    = (op == OP_NUML) ? PC_W'(pi_ff) + PC_W'(1) : PC_W'(pi_ff);
   assign num_full  = NUM_W'(pi_sel) * NUM_W'(total_ff);
   assign clamp_val = (div_quo > NUM_W'(total_ff)) ? total_ff : div_quo[IT_W-1:0];
   assign cur_inc   = cur_ff + IT_W'(1);

   always_comb begin
      case (op)
         OP_MAC1: begin
            mul_pos = pos_ff[1];
            mul_str = stride_ff[1];
         end
         OP_MAC2: begin
            mul_pos = pos_ff[2];
            mul_str = stride_ff[2];
         end
         default: begin
            mul_pos = pos_ff[0];
            mul_str = stride_ff[0];
         end
      endcase
   end

   assign mul_prod = DATA_W'(mul_pos) * mul_str;

   always_comb begin
      div_start = 1'b0;
      div_num   = num_ff;
      div_den   = DV_W'(pc_ff);
      case (op)
         OP_DIVN: begin
            div_start = 1'b1;
         end
         OP_DIV2: begin
            div_start = 1'b1;
            div_num   = NUM_W'(cur_ff);
            div_den   = DV_W'(eff[2]);
         end
         OP_DIV1: begin
            div_start = 1'b1;
            div_num   = NUM_W'(it_ff);
            div_den   = DV_W'(eff[1]);
         end
         default: begin
         end
      endcase
   end

   plig_div #(
      .NW (NUM_W),
      .DW (DV_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_num),
      .divisor   (div_den),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      base_in      = base_ff;
      stride_in    = stride_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      cur_in       = cur_ff;
      end_in       = end_ff;
      fin_in       = fin_ff;
      sdir_in      = sdir_ff;
      sorg_in      = sorg_ff;
      pi_in        = pi_ff;
      pc_in        = pc_ff;
      prod01_in    = prod01_ff;
      total_in     = total_ff;
      num_in       = num_ff;
      it_in        = it_ff;
      acc_in       = acc_ff;
      rsp_index_in = rsp_index_ff;
      rsp_sig_in   = rsp_sig_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_valid_in = rsp_valid_ff;

      if (csr_write) begin
         case (csr_index)
            REG_BASE:     base_in      = csr_data;
            REG_STRIDE_0: stride_in[0] = csr_data;
            REG_STRIDE_1: stride_in[1] = csr_data;
            REG_STRIDE_2: stride_in[2] = csr_data;
            REG_COUNT_0:  count_in[0]  = csr_data[CNT_REG_W-1:0];
            REG_COUNT_1:  count_in[1]  = csr_data[CNT_REG_W-1:0];
            REG_COUNT_2:  count_in[2]  = csr_data[CNT_REG_W-1:0];
            default: begin
            end
         endcase
      end

      case (op)
         OP_LOAD: begin
            // zero partitions means one part covering everything
            if (req_part_count == '0) begin
               pi_in = '0;
               pc_in = PC_W'(1);
            end else begin
               pi_in = req_part_index;
               pc_in = req_part_count;
            end
            if (req_cmd == CMD_START) begin
               sdir_in[0] = req_sigma_dir_1;
               sdir_in[1] = req_sigma_dir_2;
               sorg_in[0] = req_sigma_origin_1;
               sorg_in[1] = req_sigma_origin_2;
            end
         end
         OP_ADV: begin
            if (!fin_ff) begin
               cur_in = cur_inc;
               if (cur_inc >= end_ff) begin
                  fin_in = 1'b1;
                  for (int d = 0; d < NDIM; d++) pos_in[d] = '0;
               end else begin
                  pos_in = pos_adv;
                  if (carry[0]) fin_in = 1'b1;
               end
            end
         end
         OP_TOT1: prod01_in = p01_full;
         OP_TOT2: total_in  = tot_full[IT_W-1:0];
         OP_NUMF: num_in    = num_full;
         OP_NUML: num_in    = num_full;
         OP_SETF: cur_in    = clamp_val;
         OP_SETL: end_in    = clamp_val;
         OP_CHECK: begin
            if (cur_ff >= end_ff) begin
               fin_in = 1'b1;
               for (int d = 0; d < NDIM; d++) pos_in[d] = '0;
            end else begin
               fin_in = 1'b0;
            end
         end
         OP_SET2: begin
            pos_in[2] = div_rem[CB-1:0];
            it_in     = div_quo[IT_W-1:0];
         end
         OP_SET1: begin
            pos_in[1] = div_rem[CB-1:0];
            pos_in[0] = div_quo[CB-1:0];
         end
         OP_MAC0: acc_in = base_ff + mul_prod;
         OP_MAC1: acc_in = acc_ff + mul_prod;
         OP_MAC2: acc_in = acc_ff + mul_prod;
         OP_OUT: begin
            rsp_index_in  = fin_ff ? base_ff : acc_ff;
            rsp_sig_in[0] = fin_ff ? '0 : sig_val[0];
            rsp_sig_in[1] = fin_ff ? '0 : sig_val[1];
            rsp_done_in   = fin_ff;
         end
         default: begin
         end
      endcase

      if (op == OP_OUT) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         stride_ff[0] <= '0;
         stride_ff[1] <= '0;
         stride_ff[2] <= DATA_W'(1);
         count_ff[0]  <= CNT_REG_W'(1);
         count_ff[1]  <= CNT_REG_W'(1);
         count_ff[2]  <= CNT_REG_W'(1);
         for (int d = 0; d < NDIM; d++) pos_ff[d] <= '0;
         cur_ff       <= '0;
         end_ff       <= '0;
         fin_ff       <= 1'b1;
         sdir_ff[0]   <= SIG_NONE;
         sdir_ff[1]   <= SIG_NONE;
         sorg_ff[0]   <= '0;
         sorg_ff[1]   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         stride_ff    <= stride_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         cur_ff       <= cur_in;
         end_ff       <= end_in;
         fin_ff       <= fin_in;
         sdir_ff      <= sdir_in;
         sorg_ff      <= sorg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pi_ff        <= pi_in;
      pc_ff        <= pc_in;
      prod01_ff    <= prod01_in;
      total_ff     <= total_in;
      num_ff       <= num_in;
      it_ff        <= it_in;
      acc_ff       <= acc_in;
      rsp_index_ff <= rsp_index_in;
      rsp_sig_ff   <= rsp_sig_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign stat.div_done    = div_done;
   assign stat.range_empty = cur_ff >= end_ff;
   assign stat.out_free    = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_array_index   = rsp_index_ff;
   assign rsp_sigma_index_1 = rsp_sig_ff[0];
   assign rsp_sigma_index_2 = rsp_sig_ff[1];
   assign rsp_done_res      = rsp_done_ff;

endmodule

>>> bench/partitioned_nested_loop_index_generator_unit_test.sv
`timescale 1ns / 100ps

module partitioned_nested_loop_index_generator_unit_test;
   import plig_pkg::*;

   localparam int LIMIT_CYCLES    = 2000000;
   localparam int LONG_HOLD       = 400;
   localparam int PHASES          = 12;
   localparam int WORDS_PER_PHASE = 115;

   typedef struct packed {
      logic             cmd;
      logic [PI_W-1:0]  part_index;
      logic [PC_W-1:0]  part_count;
      logic [DIR_W-1:0] sigma_dir_1;
      logic [DIR_W-1:0] sigma_dir_2;
      logic [ORG_W-1:0] sigma_origin_1;
      logic [ORG_W-1:0] sigma_origin_2;
   } walk_cmd_type;

   typedef struct packed {
      logic [DATA_W-1:0] array_index;
      logic [SIG_W-1:0]  sigma_index_1;
      logic [SIG_W-1:0]  sigma_index_2;
      logic              done_res;
   } walk_result_type;

   typedef struct packed {
      logic                 is_write;
      logic [CSR_IDX_W-1:0] reg_index;
      logic [DATA_W-1:0]    reg_data;
      walk_cmd_type         word;
      logic                 typed;
      walk_result_type      result;
   } plan_row_type;

   localparam walk_cmd_type ADV_WORD = '{CMD_ADVANCE, 8'd0, 9'd0, 2'd0, 2'd0, 17'd0, 17'd0};

   logic clock;
   logic reset;

   plig_req_if req_bus ();
   plig_rsp_if rsp_bus ();
   plig_csr_if csr_bus ();

   partitioned_nested_loop_index_generator_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // walk predictor state
   logic [DATA_W-1:0]    origin_idx = '0;
   logic [DATA_W-1:0]    step_of [NDIM] = '{32'd0, 32'd0, 32'd1};
   logic [CNT_REG_W-1:0] span_reg [NDIM] = '{17'd1, 17'd1, 17'd1};
   longint unsigned      odo [NDIM] = '{0, 0, 0};
   longint unsigned      iter_at = 0;
   longint unsigned      iter_stop = 0;
   bit                   walk_idle = 1'b1;
   logic [DIR_W-1:0]     sig_dir [2] = '{SIG_NONE, SIG_NONE};
   logic [ORG_W-1:0]     sig_org [2] = '{17'd0, 17'd0};

   walk_result_type index_words_due [$];
   walk_cmd_type    seen_word;
   walk_result_type predicted_word;
   walk_result_type due_word;
   logic            row_typed;
   walk_result_type row_result;

   int  mismatch_count = 0;
   int  cycle_count = 0;
   int  hold_asked = 0;
   int  hold_served = 0;
   bit  tx_idle_on = 1'b1;
   bit  rx_stall_on = 1'b1;

   plan_row_type plan [$];

   function automatic longint unsigned span_of(input int d);
      longint unsigned v;
      if (d >= MAX_DIMS_DEF) return 1;
      v = span_reg[d];
      if (v == 0) return 1;
      if (v > (longint'(1) << COUNT_BITS_DEF)) return longint'(1) << COUNT_BITS_DEF;
      return v;
   endfunction

   function automatic logic [SIG_W-1:0] sigma_of(input int k);
      logic [31:0] s;
      if (sig_dir[k] == SIG_NONE) return '0;
      s = 32'(sig_org[k]) + (32'(odo[sig_dir[k]]) << 1);
      return s[SIG_W-1:0];
   endfunction

   task automatic load_register(input logic [CSR_IDX_W-1:0] idx,
                                input logic [DATA_W-1:0] data);
      case (idx)
         REG_BASE:     origin_idx = data;
         REG_STRIDE_0: step_of[0] = data;
         REG_STRIDE_1: step_of[1] = data;
         REG_STRIDE_2: step_of[2] = data;
         REG_COUNT_0:  span_reg[0] = data[CNT_REG_W-1:0];
         REG_COUNT_1:  span_reg[1] = data[CNT_REG_W-1:0];
         REG_COUNT_2:  span_reg[2] = data[CNT_REG_W-1:0];
         default: ;
      endcase
   endtask

   task automatic advance_walk(input walk_cmd_type w, output walk_result_type r);
      longint unsigned total, pi, pc, first, last, it, n;
      logic [DATA_W-1:0] acc;
      bit carry;
      if (w.cmd == CMD_START) begin
         total = span_of(0) * span_of(1) * span_of(2);
         pi = w.part_index;
         pc = w.part_count;
         sig_dir[0] = w.sigma_dir_1;
         sig_dir[1] = w.sigma_dir_2;
         sig_org[0] = w.sigma_origin_1;
         sig_org[1] = w.sigma_origin_2;
         if (pc == 0) begin
            pi = 0;
            pc = 1;
         end
         first = pi * total / pc;
         last = (pi + 1) * total / pc;
         if (first > total) first = total;
         if (last > total) last = total;
         iter_at = first;
         iter_stop = last;
         if (first >= last) begin
            walk_idle = 1'b1;
            foreach (odo[d]) odo[d] = 0;
         end else begin
            walk_idle = 1'b0;
            it = first;
            for (int d = NDIM - 1; d > 0; d--) begin
               n = span_of(d);
               odo[d] = it % n;
               it = it / n;
            end
            odo[0] = it;
         end
      end else if (!walk_idle) begin
         iter_at++;
         if (iter_at >= iter_stop) begin
            walk_idle = 1'b1;
            foreach (odo[d]) odo[d] = 0;
         end else begin
            carry = 1'b1;
            for (int d = NDIM - 1; d >= 0 && carry; d--) begin
               if (odo[d] + 1 < span_of(d)) begin
                  odo[d]++;
                  carry = 1'b0;
               end else begin
                  odo[d] = 0;
               end
            end
            if (carry) walk_idle = 1'b1;
         end
      end
      if (walk_idle) begin
         r = '{origin_idx, 18'd0, 18'd0, 1'b1};
      end else begin
         acc = origin_idx;
         for (int d = 0; d < NDIM; d++) acc = acc + 32'(odo[d]) * step_of[d];
         r = '{acc, sigma_of(0), sigma_of(1), 1'b0};
      end
   endtask

   function automatic walk_cmd_type start_word(input int pi, input int pc, input int d1,
                                               input int d2, input int o1, input int o2);
      return '{CMD_START, PI_W'(pi), PC_W'(pc), DIR_W'(d1), DIR_W'(d2), ORG_W'(o1), ORG_W'(o2)};
   endfunction

   function automatic walk_result_type done_word(input logic [DATA_W-1:0] b);
      return '{b, 18'd0, 18'd0, 1'b1};
   endfunction

   function automatic plan_row_type reg_row(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [DATA_W-1:0] data);
      plan_row_type r;
      r = '0;
      r.is_write = 1'b1;
      r.reg_index = idx;
      r.reg_data = data;
      return r;
   endfunction

   function automatic plan_row_type word_row(input walk_cmd_type w);
      plan_row_type r;
      r = '0;
      r.word = w;
      return r;
   endfunction

   function automatic plan_row_type checked_row(input walk_cmd_type w,
                                                input walk_result_type want);
      plan_row_type r;
      r = '0;
      r.word = w;
      r.typed = 1'b1;
      r.result = want;
      return r;
   endfunction

   task automatic add_row(input plan_row_type row);
      plan = {plan, row};
   endtask

   function automatic walk_cmd_type random_step();
      walk_cmd_type w;
      w.cmd = CMD_ADVANCE;
      w.part_index = PI_W'($urandom);
      w.part_count = PC_W'($urandom);
      w.sigma_dir_1 = DIR_W'($urandom);
      w.sigma_dir_2 = DIR_W'($urandom);
      w.sigma_origin_1 = ORG_W'($urandom);
      w.sigma_origin_2 = ORG_W'($urandom);
      return w;
   endfunction

   function automatic walk_cmd_type random_start(input bit tidy);
      walk_cmd_type w;
      int pi, pc;
      w.cmd = CMD_START;
      w.sigma_dir_1 = DIR_W'($urandom);
      w.sigma_dir_2 = DIR_W'($urandom);
      w.sigma_origin_1 = ($urandom_range(0, 7) == 0) ? '1 : ORG_W'($urandom);
      w.sigma_origin_2 = ($urandom_range(0, 7) == 0) ? '1 : ORG_W'($urandom);
      if (tidy) begin
         pc = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
         pi = (pc == 0) ? $urandom_range(0, 255) : $urandom_range(0, pc - 1);
         if ($urandom_range(0, 15) == 0) pi = pc + $urandom_range(0, 3);
      end else begin
         pc = $urandom_range(0, 256);
         pi = $urandom_range(0, 255);
      end
      w.part_index = PI_W'(pi);
      w.part_count = PC_W'(pc);
      return w;
   endfunction

   function automatic logic [DATA_W-1:0] pick_reg_value(input logic [CSR_IDX_W-1:0] idx,
                                                        input bit wide);
      logic [DATA_W-1:0] cnt;
      if (idx < REG_COUNT_0) begin
         case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return $urandom_range(0, 16);
            default: return $urandom;
         endcase
      end
      if (!wide) begin
         cnt = $urandom_range(0, 4);
      end else begin
         case ($urandom_range(0, 7))
            0: cnt = 0;
            1: cnt = 1;
            2: cnt = 2;
            3: cnt = 65535;
            4: cnt = 65536;
            5: cnt = 65537;
            6: cnt = 131071;
            default: cnt = $urandom_range(0, 131071);
         endcase
      end
      return ($urandom & 32'hFFFE_0000) | cnt;
   endfunction

   function automatic int tx_gap();
      int r;
      if (!tx_idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 75) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int rx_gap();
      int r;
      if (!rx_stall_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_word(input walk_cmd_type w, input bit typed,
                            input walk_result_type want);
      int gap;
      gap = tx_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd <= w.cmd;
      req_bus.part_index <= w.part_index;
      req_bus.part_count <= w.part_count;
      req_bus.sigma_dir_1 <= w.sigma_dir_1;
      req_bus.sigma_dir_2 <= w.sigma_dir_2;
      req_bus.sigma_origin_1 <= w.sigma_origin_1;
      req_bus.sigma_origin_2 <= w.sigma_origin_2;
      row_typed <= typed;
      row_result <= want;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= data;
      do @(posedge clock); while (!csr_bus.ready);
   endtask

   task automatic drain_words();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (index_words_due.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                              input logic [DATA_W-1:0] got);
      if (got !== want) begin
         $error("%s expected %h got %h", name, want, got);
         mismatch_count++;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("partitioned_nested_loop_index_generator_unit_test failed");
         $finish;
      end
   end

   // accepted config and input words
   always @(posedge clock) begin
      if (!reset && csr_bus.valid && csr_bus.ready) load_register(csr_bus.index, csr_bus.data);
      if (!reset && req_bus.valid && req_bus.ready) begin
         seen_word = '{req_bus.cmd, req_bus.part_index, req_bus.part_count,
                       req_bus.sigma_dir_1, req_bus.sigma_dir_2,
                       req_bus.sigma_origin_1, req_bus.sigma_origin_2};
         advance_walk(seen_word, predicted_word);
         index_words_due = {index_words_due, (row_typed ? row_result : predicted_word)};
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (index_words_due.size() == 0) begin
            $error("result word with nothing expected");
            mismatch_count++;
         end else begin
            due_word = index_words_due.pop_front();
            check_field("array_index", due_word.array_index, rsp_bus.array_index);
            check_field("sigma_index_1", 32'(due_word.sigma_index_1), 32'(rsp_bus.sigma_index_1));
            check_field("sigma_index_2", 32'(due_word.sigma_index_2), 32'(rsp_bus.sigma_index_2));
            check_field("done_res", 32'(due_word.done_res), 32'(rsp_bus.done_res));
         end
      end
   end

   initial begin
      int gap;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            gap = LONG_HOLD;
         end else begin
            gap = rx_gap();
         end
         if (gap == 0) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      int phase_words, n, r;
      longint unsigned est, pc_eff;
      walk_cmd_type w;
      bit wide;

      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.cmd <= CMD_START;
      req_bus.part_index <= '0;
      req_bus.part_count <= '0;
      req_bus.sigma_dir_1 <= '0;
      req_bus.sigma_dir_2 <= '0;
      req_bus.sigma_origin_1 <= '0;
      req_bus.sigma_origin_2 <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= REG_BASE;
      csr_bus.data <= '0;
      row_typed <= 1'b0;
      row_result <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      add_row(checked_row(ADV_WORD, done_word(32'd0)));
      add_row(checked_row(start_word(0, 0, 0, SIG_NONE, 5, 9),
                          walk_result_type'{32'd0, 18'd5, 18'd0, 1'b0}));
      add_row(checked_row(ADV_WORD, done_word(32'd0)));
      add_row(checked_row(ADV_WORD, done_word(32'd0)));
      add_row(reg_row(REG_BASE, 32'hFFFF_FFFF));
      add_row(reg_row(REG_STRIDE_0, 32'hFFFF_FFFF));
      add_row(reg_row(REG_STRIDE_1, 32'h0001_0000));
      add_row(reg_row(REG_STRIDE_2, 32'hFFFF_FFFF));
      add_row(reg_row(REG_COUNT_0, 32'hFFFE_0000));
      add_row(reg_row(REG_COUNT_1, 32'h0001_FFFF));
      add_row(reg_row(REG_COUNT_2, 32'h0001_0000));
      add_row(word_row(start_word(255, 256, 1, 2, 0, 131071)));
      add_row(word_row(ADV_WORD));
      add_row(word_row(ADV_WORD));
      add_row(checked_row(start_word(255, 255, 0, 1, 7, 7), done_word(32'hFFFF_FFFF)));
      add_row(checked_row(start_word(200, 0, 0, 1, 131071, 131071),
                          walk_result_type'{32'hFFFF_FFFF, 18'h1FFFF, 18'h1FFFF, 1'b0}));
      add_row(word_row(ADV_WORD));
      add_row(word_row(start_word(128, 256, 2, SIG_NONE, 131071, 3)));
      add_row(checked_row(start_word(7, 3, 1, 2, 1, 1), done_word(32'hFFFF_FFFF)));
      add_row(reg_row(REG_BASE, 32'd1000));
      add_row(reg_row(REG_STRIDE_0, 32'd100));
      add_row(reg_row(REG_STRIDE_1, 32'd10));
      add_row(reg_row(REG_STRIDE_2, 32'd1));
      add_row(reg_row(REG_COUNT_0, 32'd2));
      add_row(reg_row(REG_COUNT_1, 32'd3));
      add_row(reg_row(REG_COUNT_2, 32'd4));
      add_row(word_row(start_word(1, 3, 0, 2, 1, 131071)));
      repeat (7) add_row(word_row(ADV_WORD));
      add_row(checked_row(ADV_WORD, done_word(32'd1000)));
      add_row(checked_row(ADV_WORD, done_word(32'd1000)));

      foreach (plan[i]) begin
         if (plan[i].is_write) begin
            drain_words();
            write_reg(plan[i].reg_index, plan[i].reg_data);
            csr_bus.valid <= 1'b0;
         end else begin
            send_word(plan[i].word, plan[i].typed, plan[i].result);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         wide = (p % 4 == 3);
         drain_words();
         for (int i = REG_BASE; i <= REG_COUNT_2; i++)
            write_reg(CSR_IDX_W'(i), pick_reg_value(CSR_IDX_W'(i), wide));
         csr_bus.valid <= 1'b0;
         tx_idle_on = (p % 3 != 1);
         rx_stall_on = (p % 4 != 2);
         if (p == 2 || p == 7) hold_asked++;
         phase_words = 0;
         // carry on the previous walk under the new registers
         if (p > 0 && $urandom_range(0, 1) == 1) begin
            n = $urandom_range(1, 6);
            repeat (n) begin
               send_word(random_step(), 1'b0, '0);
               phase_words++;
            end
         end
         while (phase_words < WORDS_PER_PHASE) begin
            r = $urandom_range(0, 9);
            if (r == 0) begin
               send_word(random_start(1'b0), 1'b0, '0);
               phase_words++;
            end else if (r == 1) begin
               n = $urandom_range(1, 4);
               repeat (n) begin
                  send_word(random_step(), 1'b0, '0);
                  phase_words++;
               end
            end else begin
               w = random_start(1'b1);
               pc_eff = (w.part_count == 0) ? 1 : w.part_count;
               est = span_of(0) * span_of(1) * span_of(2) / pc_eff + 2;
               if (est > 40) est = $urandom_range(4, 40);
               n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, int'(est)) : int'(est);
               send_word(w, 1'b0, '0);
               phase_words++;
               repeat (n) begin
                  send_word(random_step(), 1'b0, '0);
                  phase_words++;
               end
            end
         end
      end

      drain_words();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("partitioned_nested_loop_index_generator_unit_test passed");
      end else begin
         $display("partitioned_nested_loop_index_generator_unit_test failed");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/plig_pkg.sv
sv/plig_if.sv
sv/plig_div.sv
sv/plig_ctrl.sv
sv/plig_dp.sv
sv/partitioned_nested_loop_index_generator_unit.sv
bench/partitioned_nested_loop_index_generator_unit_test.sv
